@@ rtl/core/ueh_pkg.sv @@
package ueh_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned LIMIT_W = 10;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [BYTE_W-1:0] ESCAPE_MARK = 8'h5F;  // '_'
  localparam logic [BYTE_W-1:0] CH_0  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LA = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h66;
  localparam logic [BYTE_W-1:0] CH_UA = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UF = 8'h46;

  localparam logic        UNIT_MODE_RESET    = 1'b0;
  localparam logic [9:0]  OUTPUT_LIMIT_RESET = 10'd1023;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_UNIT_MODE    = 1'b0,
    REG_OUTPUT_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code_byte;
    logic              final_byte;
  } item_t;

  typedef struct packed {
    logic [UNIT_W-1:0] decoded_value;
    logic              value_valid;
    logic              string_done;
    logic              truncated;
  } result_t;

  // non-hex characters decode as zero
  function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] ch);
    logic [BYTE_W-1:0] d;
    d = '0;
    if (ch >= CH_0 && ch <= CH_9) begin
      d = ch - CH_0;
    end else if (ch >= CH_LA && ch <= CH_LF) begin
      d = ch - CH_LA + 8'd10;
    end else if (ch >= CH_UA && ch <= CH_UF) begin
      d = ch - CH_UA + 8'd10;
    end
    return d[3:0];
  endfunction

endpackage

@@ rtl/core/ueh_in_stage.sv @@
module ueh_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,
  input  logic          s_axis_tlast,
  input  logic          advance,
  output logic          item_valid,
  output ueh_pkg::item_t item
);
  import ueh_pkg::*;

  logic load;

  assign s_axis_tready = !item_valid || advance;
  assign load = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.code_byte  <= s_axis_tdata[BYTE_W-1:0];
      item.final_byte <= s_axis_tlast;
    end
  end

endmodule

@@ rtl/core/ueh_core.sv @@
module ueh_core #(
  parameter int unsigned OUTPUT_CAPACITY = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  ueh_pkg::item_t   item,
  input  logic             unit_mode,
  input  logic [9:0]       output_limit,
  output logic             emit,
  output ueh_pkg::result_t res
);
  import ueh_pkg::*;

  localparam int unsigned CNT_W = $clog2(OUTPUT_CAPACITY);
  localparam logic [LIMIT_W-1:0] CAP_MAX = LIMIT_W'(OUTPUT_CAPACITY - 1);

  phase_t            phase, phase_next;
  logic [3:0]        high_nibble, high_nibble_next;
  logic [BYTE_W-1:0] pending_low, pending_low_next;
  logic              low_held, low_held_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              limit_hit, limit_hit_next;

  logic [LIMIT_W-1:0] eff_limit;
  logic               have, produce, fin;
  logic [BYTE_W-1:0]  val;
  logic [UNIT_W-1:0]  unit;

  assign eff_limit = (output_limit > CAP_MAX) ? CAP_MAX : output_limit;
  assign fin = item.final_byte;

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    pending_low_next = pending_low;
    low_held_next    = low_held;
    count_next       = count;
    limit_hit_next   = limit_hit;
    have    = 1'b0;
    produce = 1'b0;
    val     = '0;
    unit    = '0;

    if (LIMIT_W'(count) >= eff_limit) begin
      limit_hit_next = 1'b1;
    end else begin
      case (phase)
        PH_MARK: begin
          if (fin) begin
            val        = {4'd0, hex_value(item.code_byte)};
            have       = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            high_nibble_next = hex_value(item.code_byte);
            phase_next       = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          val        = {high_nibble, hex_value(item.code_byte)};
          have       = 1'b1;
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
          if (item.code_byte == ESCAPE_MARK) begin
            if (!fin) phase_next = PH_MARK;
          end else begin
            val  = item.code_byte;
            have = 1'b1;
          end
        end
      endcase

      if (have) begin
        if (!unit_mode) begin
          unit    = {8'd0, val};
          produce = 1'b1;
        end else if (low_held) begin
          unit          = {val, pending_low};
          low_held_next = 1'b0;
          produce       = 1'b1;
        end else if (fin) begin
          unit    = {8'd0, val};
          produce = 1'b1;
        end else begin
          pending_low_next = val;
          low_held_next    = 1'b1;
        end
      end
      if (produce) count_next = count + 1'b1;
    end

    emit              = produce || fin;
    res.decoded_value = unit;
    res.value_valid   = produce;
    res.string_done   = fin;
    res.truncated     = limit_hit_next;

    // string end clears all string state
    if (fin) begin
      phase_next       = PH_IDLE;
      high_nibble_next = '0;
      pending_low_next = '0;
      low_held_next    = 1'b0;
      count_next       = '0;
      limit_hit_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      high_nibble <= '0;
      pending_low <= '0;
      low_held    <= 1'b0;
      count       <= '0;
      limit_hit   <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      pending_low <= pending_low_next;
      low_held    <= low_held_next;
      count       <= count_next;
      limit_hit   <= limit_hit_next;
    end
  end

endmodule

@@ rtl/core/ueh_out_stage.sv @@
module ueh_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             emit,
  input  ueh_pkg::result_t res,
  output logic             advance,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  import ueh_pkg::*;

  result_t res_q;

  assign advance = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata = res_q.decoded_value;
  assign m_axis_tuser = {res_q.truncated, res_q.value_valid};
  assign m_axis_tlast = res_q.string_done;

endmodule

@@ rtl/core/underscore_hex_escape_decoder.sv @@
// channel  | direction | ports                          | payload
// s_axis   | in        | tvalid tready tdata tlast      | code_byte, final_byte
// m_axis   | out       | tvalid tready tdata tuser tlast| decoded_value, flags, string_done
// cfg      | in        | cfg_we cfg_index cfg_data      | unit_mode, output_limit
//
// One request per cycle while m_axis_tready stays high; from input to output a
// request passes the input register, then the result register.
// Synchronous active-high rst clears string state and loads register defaults.
// m_axis_tready low holds the result; the input register then fills and
// s_axis_tready drops.
module underscore_hex_escape_decoder #(
  parameter int unsigned OUTPUT_CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] decoded_value
  output logic [1:0]  m_axis_tuser,   // [0] value_valid, [1] truncated
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [ueh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [9:0]  cfg_data
);
  import ueh_pkg::*;

  logic    unit_mode;
  logic [9:0] output_limit;
  logic    advance, item_valid, step, emit;
  item_t   item;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_mode    <= UNIT_MODE_RESET;
      output_limit <= OUTPUT_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_UNIT_MODE:    unit_mode    <= cfg_data[0];
        REG_OUTPUT_LIMIT: output_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign step = item_valid && advance;

  ueh_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  ueh_core #(
    .OUTPUT_CAPACITY (OUTPUT_CAPACITY)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .item         (item),
    .unit_mode    (unit_mode),
    .output_limit (output_limit),
    .emit         (emit),
    .res          (res)
  );

  ueh_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .emit          (emit),
    .res           (res),
    .advance       (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ sim/escape_decode_checker.sv @@
`timescale 1ns / 100ps

module escape_decode_checker #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] code_byte
  input  logic                            s_axis_tlast,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [15:0]                     m_axis_tdata,   // [15:0] decoded_value
  input  logic [1:0]                      m_axis_tuser,   // [0] value_valid, [1] truncated
  input  logic                            m_axis_tlast,
  input  logic                            cfg_we,
  input  logic [ueh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [9:0]                      cfg_data,
  output int unsigned                     mismatches,
  output int unsigned                     pending
);
  import ueh_pkg::*;

  result_t    due_units[$];
  result_t    seen;
  result_t    want;
  int unsigned miss;

  logic       utf16;
  logic [9:0] limit;
  phase_t     esc;
  logic [3:0] hi_nib;
  logic [7:0] low_byte;
  logic       low_held;
  logic [9:0] emit_cnt;
  logic       trunc_seen;

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return c[3:0];
    if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  task automatic close_string();
    esc        = PH_IDLE;
    hi_nib     = '0;
    low_byte   = '0;
    low_held   = 1'b0;
    emit_cnt   = '0;
    trunc_seen = 1'b0;
  endtask

  task automatic decode_request(input logic [7:0] b, input logic fin);
    logic [9:0]  cap;
    logic        got;
    logic        emit;
    logic [7:0]  val;
    logic [15:0] unit;
    result_t     r;
    cap  = (limit > CAPACITY - 1) ? 10'(CAPACITY - 1) : limit;
    got  = 1'b0;
    emit = 1'b0;
    val  = '0;
    unit = '0;
    if (emit_cnt >= cap) begin
      trunc_seen = 1'b1;
    end else begin
      case (esc)
        PH_MARK: begin
          if (fin) begin
            val = {4'h0, digit_of(b)};
            got = 1'b1;
            esc = PH_IDLE;
          end else begin
            hi_nib = digit_of(b);
            esc = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          val = {hi_nib, digit_of(b)};
          got = 1'b1;
          esc = PH_IDLE;
        end
        default: begin
          esc = PH_IDLE;
          if (b == ESCAPE_MARK) begin
            if (!fin) esc = PH_MARK;
          end else begin
            val = b;
            got = 1'b1;
          end
        end
      endcase
      if (got) begin
        if (!utf16) begin
          unit = {8'h00, val};
          emit = 1'b1;
        end else if (low_held) begin
          unit = {val, low_byte};
          low_held = 1'b0;
          emit = 1'b1;
        end else if (fin) begin
          unit = {8'h00, val};
          emit = 1'b1;
        end else begin
          low_byte = val;
          low_held = 1'b1;
        end
      end
      if (emit) emit_cnt = emit_cnt + 10'd1;
    end
    if (emit || fin) begin
      r.decoded_value = unit;
      r.value_valid   = emit;
      r.string_done   = fin;
      r.truncated     = trunc_seen;
      due_units.push_back(r);
    end
    if (fin) close_string();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      utf16 = UNIT_MODE_RESET;
      limit = OUTPUT_LIMIT_RESET;
      close_string();
      due_units.delete();
      miss = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_UNIT_MODE:    utf16 = cfg_data[0];
          REG_OUTPUT_LIMIT: limit = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) decode_request(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.decoded_value = m_axis_tdata;
        seen.value_valid   = m_axis_tuser[0];
        seen.string_done   = m_axis_tlast;
        seen.truncated     = m_axis_tuser[1];
        if (due_units.size() == 0) begin
          miss++;
          if (miss <= 10)
            $display("%0t unexpected result: value %h valid %b done %b trunc %b", $realtime,
                     seen.decoded_value, seen.value_valid, seen.string_done, seen.truncated);
        end else begin
          want = due_units.pop_front();
          if (seen.decoded_value !== want.decoded_value || seen.value_valid !== want.value_valid
              || seen.string_done !== want.string_done || seen.truncated !== want.truncated) begin
            miss++;
            if (miss <= 10)
              $display("%0t mismatch: want %h/%b/%b/%b got %h/%b/%b/%b",
                       $realtime, want.decoded_value, want.value_valid, want.string_done,
                       want.truncated, seen.decoded_value, seen.value_valid,
                       seen.string_done, seen.truncated);
          end
        end
      end
    end
    mismatches <= miss;
    pending    <= due_units.size();
  end

endmodule

@@ sim/underscore_hex_escape_decoder_test.sv @@
`timescale 1ns / 100ps

module underscore_hex_escape_decoder_test;
  import ueh_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;   // [7:0] code_byte
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [15:0]            m_axis_tdata;   // [15:0] decoded_value
  logic [1:0]             m_axis_tuser;   // [0] value_valid, [1] truncated
  logic                   m_axis_tlast;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [9:0]             cfg_data;

  int unsigned mismatches;
  int unsigned pending;
  logic        quiet;
  logic        squeeze;
  int unsigned fed;

  underscore_hex_escape_decoder dut (.*);

  escape_decode_checker decode_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, one long hold-off when asked
  initial begin
    int  hold;
    bit  held;
    hold = 0;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !held) begin
        held = 1'b1;
        hold = 150;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 11);
      end
    end
  end

  initial begin
    int unsigned dry;
    dry = 0;
    while (dry < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst) dry = 0;
      else dry++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic fin);
    while (!quiet && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    fed++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic mode, input logic [9:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNIT_MODE;
    cfg_data  <= {9'd0, mode};
    @(posedge clk);
    cfg_index <= REG_OUTPUT_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(21);
    if (r < 10) return 8'(CH_0 + r);
    if (r < 16) return 8'(CH_LA + r - 10);
    return 8'(CH_UA + r - 16);
  endfunction

  task automatic send_string(input bit close);
    logic [7:0] text[$];
    int n;
    int k;
    int r;
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        text.push_back(8'($urandom_range(255)));
      end else begin
        text.push_back(ESCAPE_MARK);
        if (r < 75) begin
          text.push_back(hex_char());
          text.push_back(hex_char());
        end else if (r < 85) begin
          text.push_back(8'($urandom_range(255)));
          text.push_back(8'($urandom_range(255)));
        end else if (r < 95) begin
          text.push_back(hex_char());
        end
      end
    end
    for (k = 0; k < text.size(); k++) push_byte(text[k], close && (k == text.size() - 1));
  endtask

  initial begin
    int         p;
    int         k;
    logic       mode;
    logic [9:0] lim;
    logic [7:0] b;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_UNIT_MODE;
    cfg_data      <= '0;
    quiet         <= 1'b0;
    squeeze       <= 1'b0;
    fed = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // byte mode: plain bytes, escapes, non-hex digits, lone digit, trailing mark
    program_regs(1'b0, 10'd1023);
    push_byte(8'h41, 0); push_byte(8'h00, 0); push_byte(8'hFF, 0);
    push_byte(ESCAPE_MARK, 0); push_byte(8'h34, 0); push_byte(8'h61, 0);
    push_byte(ESCAPE_MARK, 0); push_byte(8'h46, 0); push_byte(8'h66, 0);
    push_byte(ESCAPE_MARK, 0); push_byte(8'h7A, 0); push_byte(8'h7A, 0);
    push_byte(ESCAPE_MARK, 0); push_byte(8'h35, 1);
    push_byte(8'h78, 0); push_byte(ESCAPE_MARK, 1);
    settle();

    // UTF-16: pair, lone low byte at end, broken pair, mode switch with byte held
    program_regs(1'b1, 10'd1023);
    push_byte(8'h61, 0); push_byte(8'h62, 0); push_byte(8'h63, 1);
    push_byte(8'h64, 0); push_byte(ESCAPE_MARK, 1);
    push_byte(8'h61, 0);
    settle();
    program_regs(1'b0, 10'd1023);
    push_byte(8'h62, 1);
    settle();

    for (p = 0; p < 9; p++) begin
      case (p)
        0:       begin mode = 1'b1; lim = 10'd1023; end
        1:       begin mode = 1'b0; lim = 10'd0;    end
        2:       begin mode = 1'b1; lim = 10'd1;    end
        3:       begin mode = 1'b0; lim = 10'd3;    end
        4:       begin mode = 1'b0; lim = 10'd1023; end
        5:       begin mode = 1'b1; lim = 10'd2;    end
        6:       begin mode = 1'b0; lim = 10'd1023; end
        7:       begin mode = 1'b1; lim = 10'd7;    end
        default: begin mode = 1'b0; lim = 10'd1;    end
      endcase
      program_regs(mode, lim);
      if (p == 4) begin
        // one string past the full limit, receiver held off at its start
        squeeze <= 1'b1;
        for (k = 0; k < 1030; k++) begin
          b = 8'($urandom_range(255));
          if (b == ESCAPE_MARK) b = b ^ 8'h01;
          push_byte(b, k == 1029);
        end
      end else begin
        quiet <= (p == 6);
        fed = 0;
        while (fed < 40) send_string(1'b1);
        if ($urandom_range(1) == 1) send_string(1'b0);
      end
      settle();
      quiet <= 1'b0;
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ underscore_hex_escape_decoder.f @@
rtl/core/ueh_pkg.sv
rtl/core/ueh_in_stage.sv
rtl/core/ueh_core.sv
rtl/core/ueh_out_stage.sv
rtl/core/underscore_hex_escape_decoder.sv
sim/escape_decode_checker.sv
sim/underscore_hex_escape_decoder_test.sv
